@@ sv/encoder_tof_height_fusion_assert.svh @@
// assertion macros for the height fusion block
`ifndef ENCODER_TOF_HEIGHT_FUSION_ASSERT_SVH
`define ENCODER_TOF_HEIGHT_FUSION_ASSERT_SVH

// same-cycle implication, checked on every clock edge out of reset
`define ETF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("etf check failed");

// next-cycle implication
`define ETF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("etf check failed");

`endif

@@ sv/etf_pkg.sv @@
`timescale 1ns / 1ps
package etf_pkg;

  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 21;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int MUL_STEPS = MUL_B_W;
  localparam int DIV_N_W   = 54;
  localparam logic [6:0] DIV_DEN = 7'd125;

  localparam logic [2:0] CFG_HPC    = 3'd0;
  localparam logic [2:0] CFG_SPEED  = 3'd1;
  localparam logic [2:0] CFG_MARGIN = 3'd2;
  localparam logic [2:0] CFG_RGAIN  = 3'd3;
  localparam logic [2:0] CFG_AGAIN  = 3'd4;
  localparam logic [2:0] CFG_WINDOW = 3'd5;
  localparam logic [2:0] CFG_BIAS   = 3'd6;
  localparam logic [2:0] CFG_ENABLE = 3'd7;

  localparam logic signed [48:0] H_MAX = 49'sd8388607;
  localparam logic signed [48:0] H_MIN = -49'sd8388608;
  localparam logic signed [55:0] AHQ_MAX = 56'sd549755748352;
  localparam logic signed [55:0] AHQ_MIN = -56'sd549755813888;

  typedef enum logic [3:0] {
    S_IDLE, S_PRE, S_MSTART, S_MWAIT, S_DWAIT, S_ENC, S_TRK,
    S_GSTART, S_GWAIT, S_ASTART, S_AWAIT, S_ENC2, S_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
  } div_req_t;

  function automatic logic [23:0] sat24(input logic signed [48:0] x);
    if (x > H_MAX) return 24'h7fffff;
    if (x < H_MIN) return 24'h800000;
    return x[23:0];
  endfunction

  // round a q16 anchor plus encoder travel to micrometres
  function automatic logic [23:0] enc_um(input logic signed [39:0] ahq,
                                         input logic signed [47:0] dq);
    logic signed [48:0] s;
    logic signed [48:0] r;
    s = 49'(ahq) + 49'(dq) + 49'sd32768;
    r = s >>> 16;
    return sat24(r);
  endfunction

endpackage

@@ sv/etf_mul.sv @@
`timescale 1ns / 1ps
module etf_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  etf_pkg::mul_req_t            req,
  output logic                         busy,
  output logic                         done,
  output logic [etf_pkg::MUL_P_W-1:0]  prod
);

  localparam int CNT_W = $clog2(etf_pkg::MUL_STEPS);

  logic [etf_pkg::MUL_P_W-1:0] a_sh;
  logic [etf_pkg::MUL_B_W-1:0] b_sh;
  logic [CNT_W-1:0]            cnt;

  // one multiplier bit per cycle, shift-add
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(etf_pkg::MUL_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      prod <= '0;
      a_sh <= etf_pkg::MUL_P_W'(req.a);
      b_sh <= req.b;
    end else if (busy) begin
      if (b_sh[0]) prod <= prod + a_sh;
      a_sh <= {a_sh[etf_pkg::MUL_P_W-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[etf_pkg::MUL_B_W-1:1]};
    end
  end

endmodule

@@ sv/etf_div.sv @@
`timescale 1ns / 1ps
module etf_div (
  input  logic                         clk,
  input  logic                         rst,
  input  etf_pkg::div_req_t            req,
  output logic                         busy,
  output logic                         done,
  output logic [etf_pkg::DIV_N_W-1:0]  quo
);

  localparam int CNT_W = $clog2(etf_pkg::DIV_N_W);

  logic [6:0]       rem;
  logic [CNT_W-1:0] cnt;
  logic [7:0]       trial;
  logic             qbit;

  // restoring division by the constant, one quotient bit per cycle
  assign trial = {rem, quo[etf_pkg::DIV_N_W-1]};
  assign qbit  = (trial >= {1'b0, etf_pkg::DIV_DEN});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(etf_pkg::DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.num;
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? 7'(trial - {1'b0, etf_pkg::DIV_DEN}) : trial[6:0];
      quo <= {quo[etf_pkg::DIV_N_W-2:0], qbit};
    end
  end

endmodule

@@ sv/encoder_tof_height_fusion.sv @@
`timescale 1ns / 1ps
// steps: anchor check, encoder product, divide, track, then the range pull and, when
// that runs as well, the re-anchor; one request at a time
// next request accepted the cycle after the result is loaded, so the request rate is
// set by output stalls, by the bit-serial multiplier (up to three products) and by
// the divide by 125
// reset: control state and estimate cleared, config registers to defaults
module encoder_tof_height_fusion (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic signed [31:0] encoder_count,
  input  logic               range_valid,
  input  logic [12:0]        range_mm,
  input  logic [15:0]        elapsed_ms,
  input  logic signed [23:0] anchor_height_um,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               fused_valid,
  output logic signed [23:0] fused_height_um,
  output logic               encoder_height_valid,
  output logic signed [23:0] encoder_height_um,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [20:0]        cfg_data
);

  etf_pkg::state_t state, state_next;

  // config
  logic signed [20:0] hpc, bias;
  logic [15:0] speed;
  logic [19:0] margin, window;
  logic [16:0] rgain, again;
  logic        enable;

  // latched request
  logic        op_l, rv_l;
  logic [31:0] count_l;
  logic [12:0] range_l;
  logic [15:0] dt_l;
  logic [23:0] anchor_l;

  // fusion state
  logic               anchored, ready, prev_ok;
  logic signed [39:0] ahq;
  logic [31:0]        acount;
  logic signed [23:0] est, prev, enc;

  // work registers
  logic               msign, jump_en, reanchor_ok;
  logic [32:0]        jump_lim;
  logic signed [47:0] dq;
  logic signed [31:0] est_w;

  etf_pkg::mul_req_t mul_req;
  etf_pkg::div_req_t div_req;
  logic mul_busy, mul_done, div_busy, div_done;
  logic [etf_pkg::MUL_P_W-1:0] prod;
  logic [etf_pkg::DIV_N_W-1:0] quo;

  etf_mul u_mul (.clk, .rst, .req(mul_req), .busy(mul_busy), .done(mul_done), .prod);
  etf_div u_div (.clk, .rst, .req(div_req), .busy(div_busy), .done(div_done), .quo);

  logic range_ok, auto_anc;
  logic [23:0] tof;
  logic signed [24:0] tb;
  logic [23:0] h_auto, h_new;
  logic signed [32:0] dc, gerr, aerr;
  logic [32:0] dc_mag, gerr_mag, aerr_mag;
  logic signed [54:0] ps;
  logic [40:0] cap;
  logic signed [24:0] dd;
  logic [24:0] dd_mag;
  logic signed [31:0] est_w_next;
  logic signed [54:0] rp;
  logic signed [48:0] est_w2;
  logic signed [55:0] asum;
  logic [39:0] ahq_new;
  logic out_load;

  assign range_ok = enable & rv_l;
  assign tof      = 24'({range_l, 10'b0}) - 24'({range_l, 4'b0}) - 24'({range_l, 3'b0});
  assign auto_anc = !op_l && !anchored && range_ok;
  assign tb       = $signed({1'b0, tof}) + 25'(bias);
  assign h_auto   = etf_pkg::sat24(49'(tb));
  assign h_new    = op_l ? anchor_l : h_auto;

  assign dc       = $signed({count_l[31], count_l}) - $signed({acount[31], acount});
  assign dc_mag   = dc[32] ? 33'(-dc) : dc;
  assign gerr     = $signed({9'b0, tof}) - 33'(est_w);
  assign gerr_mag = gerr[32] ? 33'(-gerr) : gerr;
  assign aerr     = $signed({9'b0, tof}) - 33'(enc);
  assign aerr_mag = aerr[32] ? 33'(-aerr) : aerr;

  assign ps  = msign ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
  // clamp the travel in nanometres at 2^40
  assign cap = (prod > 54'(41'h100_0000_0000)) ? 41'h100_0000_0000 : prod[40:0];

  assign dd         = $signed({enc[23], enc}) - $signed({prev[23], prev});
  assign dd_mag     = dd[24] ? 25'(-dd) : dd;
  assign rp         = (ps + 55'sd32768) >>> 16;
  assign est_w2     = 49'(est_w) + rp[48:0];
  assign asum       = 56'(ahq) + 56'(ps);
  assign ahq_new    = (asum > etf_pkg::AHQ_MAX) ? etf_pkg::AHQ_MAX[39:0] :
                      (asum < etf_pkg::AHQ_MIN) ? etf_pkg::AHQ_MIN[39:0] : asum[39:0];

  always_comb begin
    est_w_next = 32'(est);
    if (anchored) begin
      if (prev_ok && jump_en) begin
        if ({8'b0, dd_mag} <= jump_lim) est_w_next = 32'(est) + 32'(dd);
      end else begin
        est_w_next = 32'(enc);
      end
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hpc    <= 21'sd1000;
      speed  <= 16'd1000;
      margin <= 20'd10000;
      rgain  <= 17'd9830;
      again  <= 17'd3277;
      window <= 20'd30000;
      bias   <= -21'sd20000;
      enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        etf_pkg::CFG_HPC:    hpc    <= cfg_data;
        etf_pkg::CFG_SPEED:  speed  <= cfg_data[15:0];
        etf_pkg::CFG_MARGIN: margin <= cfg_data[19:0];
        etf_pkg::CFG_RGAIN:  rgain  <= cfg_data[16:0];
        etf_pkg::CFG_AGAIN:  again  <= cfg_data[16:0];
        etf_pkg::CFG_WINDOW: window <= cfg_data[19:0];
        etf_pkg::CFG_BIAS:   bias   <= cfg_data;
        etf_pkg::CFG_ENABLE: enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      etf_pkg::S_IDLE:   if (in_valid) state_next = etf_pkg::S_PRE;
      etf_pkg::S_PRE:    state_next = etf_pkg::S_MSTART;
      etf_pkg::S_MSTART: state_next = etf_pkg::S_MWAIT;
      etf_pkg::S_MWAIT:  if (mul_done) state_next = etf_pkg::S_DWAIT;
      etf_pkg::S_DWAIT:  if (div_done) state_next = etf_pkg::S_ENC;
      etf_pkg::S_ENC:    state_next = etf_pkg::S_TRK;
      etf_pkg::S_TRK: begin
        if (op_l || !ready || !range_ok) state_next = etf_pkg::S_OUT;
        else state_next = etf_pkg::S_GSTART;
      end
      etf_pkg::S_GSTART: state_next = etf_pkg::S_GWAIT;
      etf_pkg::S_GWAIT: begin
        if (mul_done) state_next = reanchor_ok ? etf_pkg::S_ASTART : etf_pkg::S_OUT;
      end
      etf_pkg::S_ASTART: state_next = etf_pkg::S_AWAIT;
      etf_pkg::S_AWAIT:  if (mul_done) state_next = etf_pkg::S_ENC2;
      etf_pkg::S_ENC2:   state_next = etf_pkg::S_OUT;
      etf_pkg::S_OUT:    if (!out_valid || !out_stall) state_next = etf_pkg::S_IDLE;
      default:           state_next = etf_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall      = 1'b1;
    out_load      = 1'b0;
    mul_req.start = 1'b0;
    mul_req.a     = dc_mag;
    mul_req.b     = hpc[20] ? 21'(-hpc) : hpc;
    div_req.start = 1'b0;
    div_req.num   = {cap, 13'b0};
    unique case (state)
      etf_pkg::S_IDLE:   in_stall = 1'b0;
      etf_pkg::S_MSTART: mul_req.start = 1'b1;
      etf_pkg::S_MWAIT:  div_req.start = mul_done;
      etf_pkg::S_GSTART: begin
        mul_req.start = 1'b1;
        mul_req.a     = gerr_mag;
        mul_req.b     = 21'(rgain);
      end
      etf_pkg::S_ASTART: begin
        mul_req.start = 1'b1;
        mul_req.a     = aerr_mag;
        mul_req.b     = 21'(again);
      end
      etf_pkg::S_OUT:    out_load = !out_valid || !out_stall;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= etf_pkg::S_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_l     <= opcode;
      count_l  <= encoder_count;
      rv_l     <= range_valid;
      range_l  <= range_mm;
      dt_l     <= elapsed_ms;
      anchor_l <= anchor_height_um;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchored <= 1'b0;
      ready    <= 1'b0;
      prev_ok  <= 1'b0;
      ahq      <= '0;
      acount   <= '0;
      est      <= '0;
      prev     <= '0;
    end else begin
      unique case (state)
        etf_pkg::S_PRE: begin
          if (op_l || auto_anc) begin
            ahq      <= {h_new, 16'b0};
            acount   <= count_l;
            anchored <= 1'b1;
            est      <= h_new;
            prev     <= h_new;
            prev_ok  <= 1'b1;
            ready    <= 1'b1;
          end
        end
        etf_pkg::S_TRK: begin
          if (!op_l) begin
            if (!ready) begin
              if (range_ok) begin
                est   <= tof;
                ready <= 1'b1;
                if (anchored) begin
                  prev    <= enc;
                  prev_ok <= 1'b1;
                end
              end else if (anchored) begin
                est     <= enc;
                prev    <= enc;
                prev_ok <= 1'b1;
                ready   <= 1'b1;
              end
            end else begin
              if (anchored) begin
                prev    <= enc;
                prev_ok <= 1'b1;
              end else begin
                prev_ok <= 1'b0;
              end
              if (!range_ok) est <= etf_pkg::sat24(49'(est_w_next));
            end
          end
        end
        etf_pkg::S_GWAIT: if (mul_done) est <= etf_pkg::sat24(est_w2);
        etf_pkg::S_AWAIT: if (mul_done) ahq <= ahq_new;
        etf_pkg::S_ENC2:  prev <= etf_pkg::enc_um(ahq, dq);
        default: ;
      endcase
    end
  end

  // work registers, no reset needed
  always_ff @(posedge clk) begin
    if (state == etf_pkg::S_PRE) begin
      jump_lim <= 33'(speed * dt_l) + 33'(margin);
      jump_en  <= (dt_l != '0) && !auto_anc;
    end
    if (mul_req.start) begin
      unique case (state)
        etf_pkg::S_MSTART: msign <= dc[32] ^ hpc[20];
        etf_pkg::S_GSTART: msign <= gerr[32];
        default:           msign <= aerr[32];
      endcase
    end
    if (state == etf_pkg::S_DWAIT && div_done) begin
      dq <= msign ? -$signed({1'b0, quo[46:0]}) : $signed({1'b0, quo[46:0]});
    end
    if (state == etf_pkg::S_ENC)  enc <= etf_pkg::enc_um(ahq, dq);
    if (state == etf_pkg::S_ENC2) enc <= etf_pkg::enc_um(ahq, dq);
    if (state == etf_pkg::S_TRK) begin
      est_w       <= est_w_next;
      reanchor_ok <= anchored && (aerr_mag <= 33'(window));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fused_valid          <= ready;
      fused_height_um      <= ready ? est : '0;
      encoder_height_valid <= anchored;
      encoder_height_um    <= anchored ? enc : '0;
    end
  end

`include "encoder_tof_height_fusion_assert.svh"

  `ETF_ASSERT_NXT(a_accept_pre, in_valid && !in_stall, state == etf_pkg::S_PRE)
  `ETF_ASSERT_IMP(a_units_excl, mul_busy, !div_busy)
  `ETF_ASSERT_NXT(a_anchor_holds, anchored, anchored)
  `ETF_ASSERT_IMP(a_fused_zero, out_valid && !fused_valid, fused_height_um == '0)
  `ETF_ASSERT_IMP(a_enc_zero, out_valid && !encoder_height_valid, encoder_height_um == '0)

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;

  localparam longint HMAX = 64'sd8388607;
  localparam longint HMIN = -64'sd8388608;
  localparam longint NMLIM = 64'sd1099511627776;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic        opcode;
    logic [31:0] count;
    logic        rvalid;
    logic [12:0] range;
    logic [15:0] dt;
    logic [23:0] anchor;
  } sample_t;

  typedef struct {
    logic        fvalid;
    logic [23:0] fused;
    logic        evalid;
    logic [23:0] enc;
  } height_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic opcode = 0;
  logic signed [31:0] encoder_count = 0;
  logic range_valid = 0;
  logic [12:0] range_mm = 0;
  logic [15:0] elapsed_ms = 0;
  logic signed [23:0] anchor_height_um = 0;
  logic out_valid;
  logic out_stall = 0;
  logic fused_valid, encoder_height_valid;
  logic signed [23:0] fused_height_um, encoder_height_um;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [20:0] cfg_data = 0;

  encoder_tof_height_fusion i_dut (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // predictor copy of config and state
  longint p_hpc, p_speed, p_margin, p_rgain, p_again, p_window, p_bias, p_enable;
  bit     p_anchored, p_est_ready, p_prev_ok;
  longint p_ahq, p_acount, p_est, p_prev;

  sample_t pending_samples[$];
  height_t expected_heights[$];
  int errors = 0;
  int send_idle = 0, recv_stall = 0;
  longint cycles = 0;

  function automatic longint clamp(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint rnd16(longint x);
    x += 32768;
    if (x >= 0) return x / 65536;
    return -((-x + 65535) / 65536);
  endfunction

  function automatic longint labs(longint x);
    return x < 0 ? -x : x;
  endfunction

  function automatic longint encoder_height(longint count);
    longint dnm;
    dnm = clamp((count - p_acount) * p_hpc, -NMLIM, NMLIM);
    return clamp(rnd16(p_ahq + dnm * 8192 / 125), HMIN, HMAX);
  endfunction

  function automatic void set_anchor(longint h, longint count);
    longint e;
    p_ahq = h * 65536;
    p_acount = count;
    p_anchored = 1;
    e = encoder_height(count);
    p_est = e;
    p_prev = e;
    p_prev_ok = 1;
    p_est_ready = 1;
  endfunction

  function automatic void reset_model();
    p_hpc = 1000; p_speed = 1000; p_margin = 10000; p_rgain = 9830;
    p_again = 3277; p_window = 30000; p_bias = -20000; p_enable = 1;
    p_anchored = 0; p_ahq = 0; p_acount = 0;
    p_est_ready = 0; p_est = 0; p_prev_ok = 0; p_prev = 0;
  endfunction

  function automatic void model_config(logic [2:0] idx, logic [20:0] d);
    case (idx)
      etf_pkg::CFG_HPC:    p_hpc = longint'(signed'(d));
      etf_pkg::CFG_SPEED:  p_speed = longint'(d[15:0]);
      etf_pkg::CFG_MARGIN: p_margin = longint'(d[19:0]);
      etf_pkg::CFG_RGAIN:  p_rgain = longint'(d[16:0]);
      etf_pkg::CFG_AGAIN:  p_again = longint'(d[16:0]);
      etf_pkg::CFG_WINDOW: p_window = longint'(d[19:0]);
      etf_pkg::CFG_BIAS:   p_bias = longint'(signed'(d));
      etf_pkg::CFG_ENABLE: p_enable = longint'(d[0]);
      default: ;
    endcase
  endfunction

  function automatic height_t fuse_sample(sample_t s);
    height_t r;
    longint count, tof, dt, enc, est, d;
    bit rok;
    count = longint'(signed'(s.count));
    rok = p_enable != 0 && s.rvalid;
    tof = longint'(s.range) * 1000;
    dt = longint'(s.dt);
    enc = 0;
    if (s.opcode) begin
      set_anchor(longint'(signed'(s.anchor)), count);
    end else begin
      if (!p_anchored && rok) begin
        set_anchor(clamp(tof + p_bias, HMIN, HMAX), count);
        dt = 0;
      end
      if (p_anchored) enc = encoder_height(count);
      if (!p_est_ready) begin
        if (rok) begin
          p_est = tof;
          if (p_anchored) begin
            p_prev = enc;
            p_prev_ok = 1;
          end
          p_est_ready = 1;
        end else if (p_anchored) begin
          p_est = enc; p_prev = enc; p_prev_ok = 1; p_est_ready = 1;
        end
      end else begin
        est = p_est;
        if (p_anchored) begin
          if (p_prev_ok && dt > 0) begin
            d = enc - p_prev;
            if (labs(d) <= p_speed * dt + p_margin) est = p_est + d;
          end else begin
            est = enc;
          end
          p_prev = enc;
          p_prev_ok = 1;
        end else begin
          p_prev_ok = 0;
        end
        if (rok) begin
          est += rnd16(p_rgain * (tof - est));
          if (p_anchored && labs(tof - enc) <= p_window) begin
            p_ahq = clamp(p_ahq + p_again * (tof - enc), HMIN * 65536, HMAX * 65536);
            p_prev = encoder_height(count);
          end
        end
        p_est = clamp(est, HMIN, HMAX);
      end
    end
    r.fvalid = p_est_ready;
    r.fused = p_est_ready ? p_est[23:0] : 24'd0;
    r.evalid = p_anchored;
    r.enc = p_anchored ? 24'(encoder_height(count)) : 24'd0;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (!in_valid || !in_stall) begin
        if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
          sample_t s;
          s = pending_samples.pop_front();
          expected_heights.push_back(fuse_sample(s));
          in_valid <= 1;
          opcode <= s.opcode;
          encoder_count <= s.count;
          range_valid <= s.rvalid;
          range_mm <= s.range;
          elapsed_ms <= s.dt;
          anchor_height_um <= s.anchor;
        end else begin
          in_valid <= 0;
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_heights.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        height_t e;
        e = expected_heights.pop_front();
        if (fused_valid !== e.fvalid)
          report_mismatch("fused_valid", longint'(fused_valid), longint'(e.fvalid));
        if (fused_height_um !== e.fused)
          report_mismatch("fused_height_um", fused_height_um, signed'(e.fused));
        if (encoder_height_valid !== e.evalid)
          report_mismatch("encoder_height_valid", longint'(encoder_height_valid),
                          longint'(e.evalid));
        if (encoder_height_um !== e.enc)
          report_mismatch("encoder_height_um", encoder_height_um, signed'(e.enc));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // cfg_valid drops after each write, which keeps consecutive writes apart
  task automatic write_reg(logic [2:0] idx, logic [20:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    model_config(idx, d);
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || expected_heights.size() > 0 || in_valid)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic add(logic op, logic [31:0] c, logic rv, logic [12:0] r,
                     logic [15:0] dt, logic [23:0] a);
    sample_t s;
    s.opcode = op; s.count = c; s.rvalid = rv; s.range = r; s.dt = dt; s.anchor = a;
    pending_samples.push_back(s);
  endtask

  // mostly smooth motion with random jumps, dropouts and anchor commands
  task automatic add_random(int n, int jitter);
    logic [31:0] c;
    c = $urandom;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: c = $urandom;
        1: add(1'b1, c, 1'($urandom), 13'($urandom), 16'($urandom), 24'($urandom));
        default: c = c + $urandom_range(2 * jitter) - jitter;
      endcase
      if ($urandom_range(9) == 0)
        add(1'b0, c, 1'($urandom), 13'($urandom), 16'($urandom), 24'($urandom));
      else
        add(1'b0, c, $urandom_range(9) != 0, 13'($urandom_range(8191)),
            $urandom_range(19) == 0 ? 16'd0 : 16'($urandom_range(20)), 24'($urandom));
    end
  endtask

  initial begin
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // no range yet, then first range anchors, jump rejected, extremes
    add(1'b0, 32'd100, 1'b0, 13'd0, 16'd5, 24'd0);
    add(1'b0, 32'd200, 1'b1, 13'd500, 16'd5, 24'd0);
    add(1'b0, 32'd300, 1'b1, 13'd520, 16'd0, 24'd0);
    add(1'b0, 32'h7fffffff, 1'b1, 13'd8191, 16'd1, 24'd0);
    add(1'b0, 32'h80000000, 1'b0, 13'd8191, 16'hffff, 24'h7fffff);
    add(1'b1, 32'd0, 1'b0, 13'd0, 16'd0, 24'h7fffff);
    add(1'b1, 32'hffffffff, 1'b1, 13'h1fff, 16'hffff, 24'h800000);
    add(1'b0, 32'd10, 1'b1, 13'd0, 16'd1, 24'hffffff);
    add(1'b0, 32'd11, 1'b1, 13'd1, 16'd1, 24'd0);
    drain();

    write_reg(etf_pkg::CFG_ENABLE, 21'd0);
    add(1'b0, 32'd50, 1'b1, 13'd1000, 16'd3, 24'd0);
    add(1'b0, 32'd5000000, 1'b1, 13'd1000, 16'd3, 24'd0);
    drain();

    // gains at full scale and beyond, extreme scale and bias
    write_reg(etf_pkg::CFG_ENABLE, 21'd1);
    write_reg(etf_pkg::CFG_HPC, 21'h100000);
    write_reg(etf_pkg::CFG_SPEED, 21'd65535);
    write_reg(etf_pkg::CFG_MARGIN, 21'hfffff);
    write_reg(etf_pkg::CFG_RGAIN, 21'h1ffff);
    write_reg(etf_pkg::CFG_AGAIN, 21'h1ffff);
    write_reg(etf_pkg::CFG_WINDOW, 21'hfffff);
    write_reg(etf_pkg::CFG_BIAS, 21'h0fffff);
    add_random(60, 2000);
    drain();

    write_reg(etf_pkg::CFG_HPC, 21'h0fffff);
    write_reg(etf_pkg::CFG_SPEED, 21'd0);
    write_reg(etf_pkg::CFG_MARGIN, 21'd0);
    write_reg(etf_pkg::CFG_RGAIN, 21'd0);
    write_reg(etf_pkg::CFG_AGAIN, 21'd0);
    write_reg(etf_pkg::CFG_WINDOW, 21'd0);
    write_reg(etf_pkg::CFG_BIAS, 21'h100000);
    add_random(60, 30);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 78; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 78; end
        default: begin send_idle = 16; recv_stall = 16; end
      endcase
      write_reg(etf_pkg::CFG_HPC, 21'($urandom_range(4000) - 2000));
      write_reg(etf_pkg::CFG_SPEED, 21'($urandom_range(3000)));
      write_reg(etf_pkg::CFG_MARGIN, 21'($urandom_range(50000)));
      write_reg(etf_pkg::CFG_RGAIN, 21'($urandom_range(65536)));
      write_reg(etf_pkg::CFG_AGAIN, 21'($urandom_range(65536)));
      write_reg(etf_pkg::CFG_WINDOW, 21'($urandom_range(100000)));
      write_reg(etf_pkg::CFG_BIAS, 21'($urandom_range(100000) - 50000));
      write_reg(etf_pkg::CFG_ENABLE, 21'($urandom_range(9) != 0));
      add_random(360, 500);
      drain();
    end

    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
